[design/ring_log_entry_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Ring log entry allocator assertion macros
// Concurrent assertion shorthands used by the allocator's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef RING_LOG_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH
`define RING_LOG_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RLEA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define RLEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLEA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define RLEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/rlea_pkg.sv]
// ----------------------------------------------------------------------------
// Ring log entry allocator package
// Header field widths, mark codes, operation codes and store write enables.
// ----------------------------------------------------------------------------
`default_nettype none
package rlea_pkg;
    localparam int WORD_W = 14;
    localparam int MARK_W = 3;

    localparam logic [MARK_W-1:0] MARK_NONE   = 3'h0;
    localparam logic [MARK_W-1:0] MARK_WRAP   = 3'h1;
    localparam logic [MARK_W-1:0] MARK_INIT   = 3'h2;
    localparam logic [MARK_W-1:0] MARK_BUFFER = 3'h4;

    localparam logic        OP_ALLOC   = 1'b0;
    localparam logic        OP_MARK    = 1'b1;
    localparam logic [15:0] SIZE_LIMIT = 16'd65532;

    typedef struct packed {
        logic words_we;
        logic marks_we;
    } hdr_wen_t;
endpackage
`default_nettype wire

[design/rlea_hdr_store.sv]
// ----------------------------------------------------------------------------
// Ring log header store
// Header size and mark memories with one write port and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rlea_hdr_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire                             aclk,
    input  rlea_pkg::hdr_wen_t              wen,
    input  wire  [AW-1:0]                   waddr,
    input  wire  [rlea_pkg::WORD_W-1:0]     wdata_words,
    input  wire  [rlea_pkg::MARK_W-1:0]     wdata_marks,
    input  wire  [AW-1:0]                   raddr,
    output logic [rlea_pkg::WORD_W-1:0]     rdata_words,
    output logic [rlea_pkg::MARK_W-1:0]     rdata_marks
);
    import rlea_pkg::*;

    logic [WORD_W-1:0] words_mem [DEPTH];
    logic [MARK_W-1:0] marks_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wen.words_we) begin
            words_mem[waddr] <= wdata_words;
        end
        if (wen.marks_we) begin
            marks_mem[waddr] <= wdata_marks;
        end
        rdata_words <= words_mem[raddr];
        rdata_marks <= marks_mem[raddr];
    end
endmodule
`default_nettype wire

[design/ring_log_entry_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Ring log entry allocator
// Places variable-size records in a circular word buffer, evicting the oldest.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small sequencer around the header store,
// and s_ready is high only while the sequencer is idle. A mark item reads its
// header's marks and writes them back with the init bit set; a refused
// allocate with a bad size goes straight to the final state. An allocate
// checks for room, compares against the oldest record when the room search
// needs it, and writes its own header and the one after it. Each evicted
// record is read, the marks at the following position are read, and the
// record is retired. A wrap to the start of the ring adds two entry checks and
// two marker writes. Its latency is therefore set by the eviction walk through
// the header memory's single read port. A result that waits for the consumer
// holds the sequencer in its final state, and the next item is taken once the
// result has moved into the output register.
`default_nettype none
`include "ring_log_entry_allocator_unit_defines.svh"
module ring_log_entry_allocator_unit #(
    parameter int BUFFER_WORDS = 65536
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_operation,
    input  wire  [15:0] s_byte_size,
    input  wire         s_buffer_only,
    input  wire  [15:0] s_entry_position,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_granted,
    output logic [15:0] m_record_position,
    output logic [15:0] m_live_entries,
    output logic [31:0] m_written_total
);
    import rlea_pkg::*;

    localparam int AW  = $clog2(BUFFER_WORDS);
    localparam int SW  = ((AW > 15) ? AW : 15) + 2;
    localparam int BGW = $clog2(BUFFER_WORDS + 5);
    localparam logic [SW-1:0]  BW_S   = SW'(BUFFER_WORDS);
    localparam logic [BGW-1:0] BUDGET = BGW'(BUFFER_WORDS + 4);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MARK_RD = 4'd1;
    localparam logic [3:0] S_MARK_WR = 4'd2;
    localparam logic [3:0] S_MR_CHK  = 4'd3;
    localparam logic [3:0] S_L1_CHK  = 4'd4;
    localparam logic [3:0] S_L2_CHK  = 4'd5;
    localparam logic [3:0] S_EV_A    = 4'd6;
    localparam logic [3:0] S_EV_B    = 4'd7;
    localparam logic [3:0] S_EV_C    = 4'd8;
    localparam logic [3:0] S_WRAP_A  = 4'd9;
    localparam logic [3:0] S_WRAP_B  = 4'd10;
    localparam logic [3:0] S_ROOM    = 4'd11;
    localparam logic [3:0] S_L3_CHK  = 4'd12;
    localparam logic [3:0] S_PLACE_A = 4'd13;
    localparam logic [3:0] S_PLACE_B = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    localparam logic [1:0] CTX_L1 = 2'd0;
    localparam logic [1:0] CTX_L2 = 2'd1;
    localparam logic [1:0] CTX_L3 = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        ctx_reg, ctx_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [AW-1:0]     free_reg, free_next;
    logic [15:0]       count_reg, count_next;
    logic [31:0]       written_reg, written_next;
    logic [BGW-1:0]    budget_reg, budget_next;
    logic [SW-1:0]     space_reg, space_next;
    logic [WORD_W-1:0] words_reg, words_next;
    logic              buf_reg, buf_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     n_reg, n_next;
    logic [MARK_W-1:0] om_reg, om_next;
    logic              rgrant_reg, rgrant_next;
    logic [15:0]       rpos_reg, rpos_next;

    logic              m_valid_reg;
    logic              m_granted_reg;
    logic [15:0]       m_pos_reg, m_live_reg;
    logic [31:0]       m_written_reg;

    hdr_wen_t          wen;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wd_words, rd_words;
    logic [MARK_W-1:0] wd_marks, rd_marks;

    logic [16:0]       words_w;
    logic [SW-1:0]     needed_s, free_s, oldest_s, n_full, pos_s;
    logic [AW-1:0]     n_fix;
    logic              out_free;

    rlea_hdr_store #(
        .DEPTH (BUFFER_WORDS),
        .AW    (AW)
    ) u_store (
        .aclk        (aclk),
        .wen         (wen),
        .waddr       (waddr),
        .wdata_words (wd_words),
        .wdata_marks (wd_marks),
        .raddr       (raddr),
        .rdata_words (rd_words),
        .rdata_marks (rd_marks)
    );

    assign words_w  = ({1'b0, s_byte_size} + 17'd3) >> 2;
    assign needed_s = SW'(words_reg) + SW'(1);
    assign free_s   = SW'(free_reg);
    assign oldest_s = SW'(oldest_reg);
    assign n_full   = oldest_s + SW'(rd_words);
    assign pos_s    = SW'(s_entry_position);
    assign n_fix    = ((rd_marks & MARK_WRAP) != MARK_NONE) ? '0 : n_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready  = (state_reg == S_IDLE);

    // The sequencer. Every eviction walks through EV_A (read oldest header),
    // EV_B (compute the following position and read its marks) and EV_C
    // (retire the record); ctx_reg says which loop of the room search called.
    always_comb begin
        state_next   = state_reg;
        ctx_next     = ctx_reg;
        oldest_next  = oldest_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        written_next = written_reg;
        budget_next  = budget_reg;
        space_next   = space_reg;
        words_next   = words_reg;
        buf_next     = buf_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        om_next      = om_reg;
        rgrant_next  = rgrant_reg;
        rpos_next    = rpos_reg;
        wen          = '0;
        waddr        = free_reg;
        wd_words     = '0;
        wd_marks     = MARK_NONE;
        raddr        = oldest_reg;

        unique case (state_reg)
            S_IDLE: begin
                rgrant_next = 1'b0;
                rpos_next   = '0;
                words_next  = words_w[WORD_W-1:0];
                buf_next    = s_buffer_only;
                pos_next    = pos_s[AW-1:0];
                budget_next = BUDGET;
                if (s_valid) begin
                    if (s_operation == OP_MARK) begin
                        state_next = (pos_s < BW_S) ? S_MARK_RD : S_FIN;
                    end else if (s_byte_size == 16'd0 || s_byte_size >= SIZE_LIMIT) begin
                        state_next = S_FIN;
                    end else if (SW'(words_w) + SW'(1) > BW_S) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_MR_CHK;
                    end
                end
            end
            S_MARK_RD: begin
                raddr      = pos_reg;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                wen.marks_we = 1'b1;
                waddr        = pos_reg;
                wd_marks     = rd_marks | MARK_INIT;
                written_next = written_reg + 32'd1;
                rgrant_next  = 1'b1;
                state_next   = S_FIN;
            end
            S_MR_CHK: begin
                state_next = (free_s + needed_s > BW_S) ? S_L1_CHK : S_ROOM;
            end
            S_L1_CHK: begin
                if (oldest_reg > free_reg) begin
                    ctx_next   = CTX_L1;
                    state_next = S_EV_A;
                end else begin
                    state_next = S_L2_CHK;
                end
            end
            S_L2_CHK: begin
                if (free_reg != '0) begin
                    ctx_next   = CTX_L2;
                    state_next = S_EV_A;
                end else begin
                    state_next = S_PLACE_A;
                end
            end
            S_EV_A: begin
                raddr = oldest_reg;
                if (budget_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    budget_next = budget_reg - BGW'(1);
                    state_next  = S_EV_B;
                end
            end
            S_EV_B: begin
                n_next  = (n_full >= BW_S) ? '0 : n_full[AW-1:0];
                raddr   = (n_full >= BW_S) ? '0 : n_full[AW-1:0];
                om_next = rd_marks;
                if (ctx_reg == CTX_L3) begin
                    space_next = space_reg + SW'(rd_words);
                end
                state_next = S_EV_C;
            end
            S_EV_C: begin
                if ((om_reg & (MARK_BUFFER | MARK_INIT)) == MARK_NONE) begin
                    // Oldest record is still being written: refuse.
                    state_next = S_FIN;
                end else begin
                    if ((om_reg & MARK_BUFFER) == MARK_NONE) begin
                        count_next = count_reg - 16'd1;
                    end
                    if (n_fix == free_reg) begin
                        oldest_next = '0;
                        free_next   = '0;
                    end else begin
                        oldest_next = n_fix;
                    end
                    unique case (ctx_reg)
                        CTX_L1: state_next = S_L1_CHK;
                        CTX_L2: state_next = (free_next == '0) ? S_PLACE_A : S_WRAP_A;
                        default: state_next = (oldest_next == free_next) ? S_PLACE_A
                                                                         : S_L3_CHK;
                    endcase
                end
            end
            S_WRAP_A: begin
                wen        = '{words_we: 1'b1, marks_we: 1'b1};
                waddr      = free_reg;
                wd_marks   = MARK_WRAP;
                state_next = S_WRAP_B;
            end
            S_WRAP_B: begin
                wen        = '{words_we: 1'b1, marks_we: 1'b1};
                waddr      = '0;
                free_next  = '0;
                state_next = S_ROOM;
            end
            S_ROOM: begin
                if (oldest_reg <= free_reg) begin
                    state_next = S_PLACE_A;
                end else begin
                    space_next = oldest_s - free_s;
                    state_next = S_L3_CHK;
                end
            end
            S_L3_CHK: begin
                if (space_reg < needed_s) begin
                    ctx_next   = CTX_L3;
                    state_next = S_EV_A;
                end else begin
                    state_next = S_PLACE_A;
                end
            end
            S_PLACE_A: begin
                if (free_s + SW'(words_reg) < BW_S) begin
                    wen        = '{words_we: 1'b1, marks_we: 1'b1};
                    waddr      = free_reg;
                    wd_words   = words_reg;
                    wd_marks   = buf_reg ? MARK_BUFFER : MARK_NONE;
                    rpos_next  = 16'(free_reg);
                    state_next = S_PLACE_B;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_PLACE_B: begin
                wen         = '{words_we: 1'b1, marks_we: 1'b1};
                waddr       = free_reg + AW'(words_reg);
                free_next   = free_reg + AW'(words_reg);
                rgrant_next = 1'b1;
                if (!buf_reg) begin
                    count_next = count_reg + 16'd1;
                end
                state_next = S_FIN;
            end
            default: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            oldest_reg  <= '0;
            free_reg    <= '0;
            count_reg   <= '0;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            written_reg <= written_next;
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ctx_reg    <= ctx_next;
        budget_reg <= budget_next;
        space_reg  <= space_next;
        words_reg  <= words_next;
        buf_reg    <= buf_next;
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        om_reg     <= om_next;
        rgrant_reg <= rgrant_next;
        rpos_reg   <= rpos_next;
        if (state_reg == S_FIN && out_free) begin
            m_granted_reg <= rgrant_reg;
            m_pos_reg     <= rpos_reg;
            m_live_reg    <= count_reg;
            m_written_reg <= written_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted         = m_granted_reg;
    assign m_record_position = m_pos_reg;
    assign m_live_entries    = m_live_reg;
    assign m_written_total   = m_written_reg;

    `RLEA_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready,
        "allocator took a second item in the cycle after a transfer")
    `RLEA_ASSERT_NEXT(a_fin_delivers, aclk, aresetn, state_reg == S_FIN && out_free,
        m_valid && state_reg == S_IDLE, "finished result did not reach the output")
    `RLEA_ASSERT_IMPLY(a_free_in_ring, aclk, aresetn, 1'b1,
        free_s < BW_S && oldest_s < BW_S, "ring position left the buffer")
endmodule
`default_nettype wire

[tb/sv/ring_log_entry_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring log entry allocator testbench
// Drives allocate and mark transfers with random gaps and back-pressure, and
// checks every result against a cycle-free model of the ring held here.
// ----------------------------------------------------------------------------
module ring_log_entry_allocator_unit_tb;
    import rlea_pkg::*;

    localparam int RING_WORDS = 65536;
    localparam int RANDOM_ITEMS = 1700;

    // One row of the directed table. When known is set, the expected result is
    // typed into the row and also compared with the ring model.
    typedef struct {
        logic        op;
        logic [15:0] size;
        logic        buf_rec;
        logic [15:0] pos;
        bit          known;
        logic        granted;
        logic [15:0] rec;
        logic [15:0] live;
        logic [31:0] written;
    } stim_row_t;

    typedef struct {
        logic        granted;
        logic [15:0] rec;
        logic [15:0] live;
        logic [31:0] written;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic        s_operation = OP_ALLOC;
    logic [15:0] s_byte_size = '0;
    logic        s_buffer_only = 1'b0;
    logic [15:0] s_entry_position = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire         m_granted;
    wire  [15:0] m_record_position;
    wire  [15:0] m_live_entries;
    wire  [31:0] m_written_total;

    ring_log_entry_allocator_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_byte_size(s_byte_size),
        .s_buffer_only(s_buffer_only),
        .s_entry_position(s_entry_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_granted(m_granted),
        .m_record_position(m_record_position),
        .m_live_entries(m_live_entries),
        .m_written_total(m_written_total)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Ring model state. Only header positions that have been written are ever
    // read, both here and, through the chosen mark positions, in the block.
    logic [15:0]        ring_words [RING_WORDS];
    logic [MARK_W-1:0]  ring_marks [RING_WORDS];
    bit                 hdr_seen [RING_WORDS];
    int                 hdr_list[$];
    int                 unmarked_recs[$];
    int unsigned        oldest_pos, free_pos, walk_left;
    logic [15:0]        live_cnt;
    logic [31:0]        written_cnt;

    alloc_result_t result_fifo[$];
    int  error_cnt = 0;
    int  sent_cnt = 0;
    int  grant_cnt = 0, refuse_cnt = 0, mark_cnt = 0, wrap_cnt = 0;
    bit  stim_done = 1'b0;

    function automatic void touch_hdr(int unsigned p);
        if (!hdr_seen[p]) begin
            hdr_seen[p] = 1'b1;
            hdr_list.push_back(p);
        end
    endfunction

    function automatic int unsigned next_record(int unsigned p);
        int unsigned n;
        n = p + ring_words[p];
        if (n >= RING_WORDS) n = 0;
        if ((ring_marks[n] & MARK_WRAP) != 0) n = 0;
        return n;
    endfunction

    // Drops the oldest record. Fails on a record that is neither a raw buffer
    // nor initialized, and when the walk has run too long.
    function automatic bit evict_oldest_record();
        int unsigned n;
        logic [MARK_W-1:0] m;
        if (walk_left == 0) return 1'b0;
        walk_left--;
        n = next_record(oldest_pos);
        m = ring_marks[oldest_pos];
        if ((m & MARK_BUFFER) != 0) begin
        end else if ((m & MARK_INIT) != 0) begin
            live_cnt = live_cnt - 16'd1;
        end else begin
            return 1'b0;
        end
        if (n == free_pos) begin
            oldest_pos = 0;
            free_pos = 0;
        end else begin
            oldest_pos = n;
        end
        return 1'b1;
    endfunction

    function automatic bit make_room_for(int unsigned words);
        int unsigned needed, space, w;
        needed = words + 1;
        if (free_pos + needed > RING_WORDS) begin
            while (oldest_pos > free_pos)
                if (!evict_oldest_record()) return 1'b0;
            if (free_pos != 0 && !evict_oldest_record()) return 1'b0;
            if (free_pos == 0) return 1'b1;
            // Tail too short: leave a wrap marker and restart at word zero.
            w = free_pos;
            ring_words[w] = '0;
            ring_marks[w] = MARK_WRAP;
            touch_hdr(w);
            free_pos = 0;
            ring_words[0] = '0;
            ring_marks[0] = MARK_NONE;
            touch_hdr(0);
            wrap_cnt++;
        end
        if (oldest_pos <= free_pos) return 1'b1;
        space = oldest_pos - free_pos;
        while (space < needed) begin
            space += ring_words[oldest_pos];
            if (!evict_oldest_record()) return 1'b0;
            if (oldest_pos == free_pos) return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic alloc_result_t predict_ring(logic op, logic [15:0] size,
                                                   logic buf_rec, logic [15:0] pos);
        alloc_result_t r;
        int unsigned words, p, e;
        r.granted = 1'b0;
        r.rec = '0;
        if (op == OP_MARK) begin
            ring_marks[pos] = ring_marks[pos] | MARK_INIT;
            written_cnt = written_cnt + 32'd1;
            r.granted = 1'b1;
            mark_cnt++;
        end else if (size != 0 && size < SIZE_LIMIT) begin
            words = (int'(size) + 3) >> 2;
            walk_left = RING_WORDS + 4;
            if (words + 1 <= RING_WORDS && make_room_for(words)) begin
                p = free_pos;
                if (p + words < RING_WORDS) begin
                    e = p + words;
                    ring_words[p] = words[15:0];
                    ring_marks[p] = buf_rec ? MARK_BUFFER : MARK_NONE;
                    touch_hdr(p);
                    free_pos = e;
                    ring_words[e] = '0;
                    ring_marks[e] = MARK_NONE;
                    touch_hdr(e);
                    if (!buf_rec) begin
                        live_cnt = live_cnt + 16'd1;
                        unmarked_recs.push_back(p);
                    end
                    r.granted = 1'b1;
                    r.rec = p[15:0];
                end
            end
        end
        if (op == OP_ALLOC) begin
            if (r.granted) grant_cnt++;
            else refuse_cnt++;
        end
        r.live = live_cnt;
        r.written = written_cnt;
        return r;
    endfunction

    // Offers one item and holds it until the transfer, then records the
    // expected result. The caller decides whether valid drops afterwards, so
    // valid gets only one assignment per clock edge.
    task automatic send_item(logic op, logic [15:0] size, logic buf_rec,
                             logic [15:0] pos, output alloc_result_t r);
        s_valid <= 1'b1;
        s_operation <= op;
        s_byte_size <= size;
        s_buffer_only <= buf_rec;
        s_entry_position <= pos;
        do @(posedge aclk); while (!s_ready);
        r = predict_ring(op, size, buf_rec, pos);
        result_fifo.push_back(r);
        sent_cnt++;
    endtask

    // Mostly short gaps, now and then a long one, and runs with none at all.
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 99) < 50) ? 0 :
            ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    stim_row_t dir_rows[] = '{
        // Bad sizes are refused with nothing changed; then a one-word record is placed and marked.
        '{OP_ALLOC, 16'd0,     1'b0, 16'hFFFF, 1, 1'b0, 16'd0,     16'd0, 32'd0},
        '{OP_ALLOC, 16'd65532, 1'b0, 16'h0000, 1, 1'b0, 16'd0,     16'd0, 32'd0},
        '{OP_ALLOC, 16'hFFFF,  1'b1, 16'h5555, 1, 1'b0, 16'd0,     16'd0, 32'd0},
        '{OP_ALLOC, 16'd1,     1'b0, 16'hAAAA, 1, 1'b1, 16'd0,     16'd1, 32'd0},
        '{OP_MARK,  16'hFFFF,  1'b1, 16'd0,    1, 1'b1, 16'd0,     16'd1, 32'd1},
        // Largest records fill the ring up to word 65533.
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    1, 1'b1, 16'd1,     16'd2, 32'd1},
        '{OP_ALLOC, 16'd65531, 1'b1, 16'd0,    1, 1'b1, 16'd16384, 16'd2, 32'd1},
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    1, 1'b1, 16'd32767, 16'd3, 32'd1},
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    1, 1'b1, 16'd49150, 16'd4, 32'd1},
        // Wraps, then stops at an uninitialized record: refused.
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    1, 1'b0, 16'd0,     16'd3, 32'd1},
        '{OP_MARK,  16'd0,     1'b0, 16'd1,    1, 1'b1, 16'd0,     16'd3, 32'd2},
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    1, 1'b1, 16'd0,     16'd3, 32'd2},
        '{OP_MARK,  16'd0,     1'b0, 16'd0,    0, 0, 0, 0, 0},
        '{OP_MARK,  16'd0,     1'b0, 16'd0,    0, 0, 0, 0, 0},
        '{OP_MARK,  16'h1234,  1'b0, 16'd65533, 0, 0, 0, 0, 0},
        '{OP_ALLOC, 16'd8,     1'b1, 16'd0,    0, 0, 0, 0, 0},
        '{OP_ALLOC, 16'd65531, 1'b0, 16'd0,    0, 0, 0, 0, 0},
        '{OP_MARK,  16'd0,     1'b0, 16'd32767, 0, 0, 0, 0, 0},
        '{OP_MARK,  16'd0,     1'b0, 16'd49150, 0, 0, 0, 0, 0},
        '{OP_ALLOC, 16'd40000, 1'b0, 16'd0,    0, 0, 0, 0, 0},
        '{OP_ALLOC, 16'd3,     1'b0, 16'hFFFF, 0, 0, 0, 0, 0},
        '{OP_ALLOC, 16'd65533, 1'b0, 16'd0,    0, 0, 0, 0, 0}
    };

    initial begin : stimulus
        alloc_result_t r;
        logic op, bf;
        logic [15:0] size, pos;
        int k;
        oldest_pos = 0;
        free_pos = 0;
        live_cnt = '0;
        written_cnt = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].op, dir_rows[i].size, dir_rows[i].buf_rec,
                      dir_rows[i].pos, r);
            if (dir_rows[i].known && (r.granted !== dir_rows[i].granted ||
                    r.rec !== dir_rows[i].rec || r.live !== dir_rows[i].live ||
                    r.written !== dir_rows[i].written)) begin
                $display("%0t: table row %0d: expected %0b/%0d/%0d/%0d, model %0b/%0d/%0d/%0d",
                         $time, i, dir_rows[i].granted, dir_rows[i].rec,
                         dir_rows[i].live, dir_rows[i].written,
                         r.granted, r.rec, r.live, r.written);
                error_cnt++;
            end
            sender_gap();
        end

        // Random part: mostly small allocations, each usually followed later by
        // a mark of its header so that eviction can make progress. Some records
        // are left unmarked on purpose so that eviction blocks on them.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            bf = 1'b0;
            pos = 16'($urandom);
            size = 16'($urandom);
            k = $urandom_range(0, 99);
            if (k < 38 && (unmarked_recs.size() > 0 || hdr_list.size() > 0)) begin
                op = OP_MARK;
                if (unmarked_recs.size() > 0 && $urandom_range(0, 99) < 75) begin
                    pos = 16'(unmarked_recs.pop_front());
                end else begin
                    pos = 16'(hdr_list[$urandom_range(0, hdr_list.size() - 1)]);
                end
                if (unmarked_recs.size() > 0 && $urandom_range(0, 99) < 4)
                    void'(unmarked_recs.pop_front());
            end else begin
                op = OP_ALLOC;
                bf = ($urandom_range(0, 99) < 20);
                k = $urandom_range(0, 99);
                if (k < 80) size = 16'($urandom_range(1, 3000));
                else if (k < 93) size = 16'($urandom_range(3001, 65531));
                else if (k < 96) size = 16'd0;
                else size = 16'($urandom_range(65532, 65535));
            end
            send_item(op, size, bf, pos, r);
            sender_gap();
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stalls, plus one long hold-off in the middle of the
    // run so that the output register fills and the input stalls behind it.
    initial begin : result_check
        alloc_result_t e;
        int stall = 0;
        bit long_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    error_cnt++;
                end else begin
                    e = result_fifo.pop_front();
                    if (m_granted !== e.granted) begin
                        $display("%0t: granted expected %0b actual %0b",
                                 $time, e.granted, m_granted);
                        error_cnt++;
                    end
                    if (m_record_position !== e.rec) begin
                        $display("%0t: record_position expected %0d actual %0d",
                                 $time, e.rec, m_record_position);
                        error_cnt++;
                    end
                    if (m_live_entries !== e.live) begin
                        $display("%0t: live_entries expected %0d actual %0d",
                                 $time, e.live, m_live_entries);
                        error_cnt++;
                    end
                    if (m_written_total !== e.written) begin
                        $display("%0t: written_total expected %0d actual %0d",
                                 $time, e.written, m_written_total);
                        error_cnt++;
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!long_done && sent_cnt >= 900) begin
                long_done = 1'b1;
                stall = 300;
                m_ready <= 1'b0;
            end else if (sent_cnt < 300 || sent_cnt > 1200) begin
                // No stalls in this stretch.
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 30) begin
                stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                     : $urandom_range(10, 40);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : finish_run
        wait (stim_done);
        while (result_fifo.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d transfers: %0d granted and %0d refused allocations, %0d marks,",
                 sent_cnt, grant_cnt, refuse_cnt, mark_cnt);
        $display("%0d wraps to the ring start, with %0d header positions touched.",
                 wrap_cnt, hdr_list.size());
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #40ms;
        $display("Timeout with %0d results outstanding.", result_fifo.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule
